// ----- rtl/lpdx_pkg.sv -----
// ----------------------------------------------------------------------------
// lpdx_pkg
// Constants and result type for the lidar packet deframer.
// ----------------------------------------------------------------------------
package lpdx_pkg;

  localparam int unsigned POINTS_PER_PACKET_DEF = 40;
  localparam int unsigned HEADER_LEN            = 10;

  localparam logic [7:0]  SYNC_A     = 8'hAA;
  localparam logic [7:0]  SYNC_B     = 8'h55;
  localparam logic [7:0]  COUNT_BYTE = 8'h28;
  localparam logic [15:0] SYNC_WORD  = 16'h55AA;

  localparam logic KIND_POINT   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam int unsigned TDATA_W = 72;

  typedef struct packed {
    logic        kind;
    logic [15:0] distance;
    logic [7:0]  number;
    logic [7:0]  ct;
    logic [15:0] start_angle;
    logic [15:0] end_angle;
    logic        checksum_ok;
    logic        last;
  } lpdx_result_t;

endpackage

// ----- rtl/lidar_packet_deframer_xor_check_top.sv -----
// ----------------------------------------------------------------------------
// lidar_packet_deframer_xor_check_top
// Byte-stream packet parser for a scanning lidar with XOR-16 check.
// ----------------------------------------------------------------------------
// Takes one link byte per cycle on the slave stream and hunts for the 0xAA 0x55
// header, then the CT byte, a count byte of 0x28, the start angle, the end
// angle and the received checksum (little-endian words). Every fourth payload
// byte emits a point result with the unsigned distance from point bytes 2 and
// 3; the last payload byte also emits a packet summary with the checksum
// verdict. The parser handles each byte as it is accepted; results go
// through a four-entry output queue, so a byte is accepted every cycle while
// the queue has room for two results (a byte causes at most two).
module lidar_packet_deframer_xor_check_top #(
  parameter int unsigned POINTS_PER_PACKET = lpdx_pkg::POINTS_PER_PACKET_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,   // [7:0] data_byte
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [lpdx_pkg::TDATA_W-1:0] m_tdata,   // [15:0] point_distance,
                                                   // [23:16] point_number,
                                                   // [31:24] ct_byte,
                                                   // [47:32] start_angle,
                                                   // [63:48] end_angle,
                                                   // [64] checksum_ok, rest zero
  output logic [0:0]                   m_tuser,   // [0] result_kind
  output logic                         m_tlast    // last_of_run
);
  import lpdx_pkg::*;

  localparam int unsigned PAYLOAD_LEN = 4 * POINTS_PER_PACKET;
  localparam int unsigned POS_W       = $clog2(HEADER_LEN + PAYLOAD_LEN);
  localparam int unsigned QDEPTH      = 4;
  localparam int unsigned QPTR_W      = $clog2(QDEPTH);

  localparam logic [POS_W-1:0] POS_HUNT    = POS_W'(0);
  localparam logic [POS_W-1:0] POS_SYNC_B  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_CT      = POS_W'(2);
  localparam logic [POS_W-1:0] POS_COUNT   = POS_W'(3);
  localparam logic [POS_W-1:0] POS_FA_LO   = POS_W'(4);
  localparam logic [POS_W-1:0] POS_FA_HI   = POS_W'(5);
  localparam logic [POS_W-1:0] POS_LA_LO   = POS_W'(6);
  localparam logic [POS_W-1:0] POS_LA_HI   = POS_W'(7);
  localparam logic [POS_W-1:0] POS_CS_LO   = POS_W'(8);
  localparam logic [POS_W-1:0] POS_CS_HI   = POS_W'(9);
  localparam logic [POS_W-1:0] POS_PAYLOAD = POS_W'(HEADER_LEN);
  localparam logic [POS_W-1:0] K_LAST      = POS_W'(PAYLOAD_LEN - 1);
  localparam logic [POS_W-1:0] K_LEN       = POS_W'(PAYLOAD_LEN);

  // parser state
  logic [POS_W-1:0] pos, pos_next;
  logic [15:0]      acc, acc_next;
  logic [7:0]       low_hold, low_hold_next;
  logic [7:0]       ct_hold, ct_hold_next;
  logic [15:0]      fa_hold, fa_hold_next;
  logic [15:0]      la_hold, la_hold_next;
  logic [15:0]      rx_sum, rx_sum_next;

  // output queue
  lpdx_result_t      queue [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  logic             accept, pop;
  logic [15:0]      word;
  logic [POS_W-1:0] k;
  logic [1:0]       n_push;
  lpdx_result_t     res0, res1;

  assign accept = s_tvalid && s_tready;
  assign pop    = m_tvalid && m_tready;
  assign word   = {s_tdata, low_hold};
  assign k      = pos - POS_PAYLOAD;

  always_comb begin
    pos_next      = pos;
    acc_next      = acc;
    low_hold_next = low_hold;
    ct_hold_next  = ct_hold;
    fa_hold_next  = fa_hold;
    la_hold_next  = la_hold;
    rx_sum_next   = rx_sum;
    n_push        = 2'd0;

    res0             = '0;
    res0.kind        = KIND_POINT;
    res0.distance    = word;
    res0.number      = 8'(k >> 2);
    res0.ct          = ct_hold;
    res0.start_angle = fa_hold;
    res0.end_angle   = la_hold;
    res0.checksum_ok = 1'b0;
    res0.last        = 1'b1;

    res1             = '0;
    res1.kind        = KIND_SUMMARY;
    res1.ct          = ct_hold;
    res1.start_angle = fa_hold;
    res1.end_angle   = la_hold;
    res1.checksum_ok = ((acc ^ word) == rx_sum);
    res1.last        = 1'b1;

    case (pos)
      POS_HUNT: begin
        if (s_tdata == SYNC_A) pos_next = POS_SYNC_B;
      end
      POS_SYNC_B: begin
        if (s_tdata == SYNC_B) begin
          acc_next = SYNC_WORD;
          pos_next = POS_CT;
        end else begin
          pos_next = POS_HUNT;
        end
      end
      POS_CT: begin
        ct_hold_next = s_tdata;
        pos_next     = POS_COUNT;
      end
      POS_COUNT: begin
        if (s_tdata == COUNT_BYTE) begin
          acc_next = acc ^ {COUNT_BYTE, ct_hold};
          pos_next = POS_FA_LO;
        end else begin
          pos_next = POS_HUNT;
        end
      end
      POS_FA_LO, POS_LA_LO, POS_CS_LO: begin
        low_hold_next = s_tdata;
        pos_next      = pos + POS_W'(1);
      end
      POS_FA_HI: begin
        fa_hold_next = word;
        acc_next     = acc ^ word;
        pos_next     = POS_LA_LO;
      end
      POS_LA_HI: begin
        la_hold_next = word;
        acc_next     = acc ^ word;
        pos_next     = POS_CS_LO;
      end
      POS_CS_HI: begin
        rx_sum_next = word;
        pos_next    = POS_PAYLOAD;
      end
      default: begin
        if (k >= K_LEN) begin
          pos_next = POS_HUNT;
        end else begin
          if (!k[0]) begin
            low_hold_next = s_tdata;
          end else begin
            acc_next = acc ^ word;
            if (k[1]) n_push = 2'd1;
          end
          if (k == K_LAST) begin
            // last point and summary together; only the summary closes the run
            res0.last = 1'b0;
            n_push    = 2'd2;
            pos_next  = POS_HUNT;
          end else begin
            pos_next = pos + POS_W'(1);
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= POS_HUNT;
      acc      <= '0;
      low_hold <= '0;
      ct_hold  <= '0;
      fa_hold  <= '0;
      la_hold  <= '0;
      rx_sum   <= '0;
    end else if (accept) begin
      pos      <= pos_next;
      acc      <= acc_next;
      low_hold <= low_hold_next;
      ct_hold  <= ct_hold_next;
      fa_hold  <= fa_hold_next;
      la_hold  <= la_hold_next;
      rx_sum   <= rx_sum_next;
    end
  end

  // accept only with room for the worst case of two results
  assign s_tready = (count <= (QPTR_W+1)'(QDEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) wr_ptr <= wr_ptr + QPTR_W'(n_push);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count + (QPTR_W+1)'(accept ? n_push : 2'd0)
                     - (QPTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && n_push != 2'd0) queue[wr_ptr] <= res0;
    if (accept && n_push == 2'd2) queue[wr_ptr + QPTR_W'(1)] <= res1;
  end

  lpdx_result_t head;
  assign head     = queue[rd_ptr];
  assign m_tvalid = (count != '0);
  assign m_tdata  = {7'd0, head.checksum_ok, head.end_angle, head.start_angle,
                     head.ct, head.number, head.distance};
  assign m_tuser  = head.kind;
  assign m_tlast  = head.last;

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the lidar packet deframer with XOR-16 packet check.
// ----------------------------------------------------------------------------
// Bytes go in on the slave stream and are fed, as they are accepted, to a
// behavioural deframer kept in the bench. That deframer queues the point and
// packet summary reports that each byte should cause. A monitor pops the
// queue for every report on the master stream and compares it field by field.
// Directed tests cover header hunting, broken headers and the checksum
// verdict. Then come a stalled receiver, a sender that pauses, and a long
// random stream of packets, noise and broken headers with random gaps on
// both sides.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lpdx_pkg::*;

  localparam int NPTS        = POINTS_PER_PACKET_DEF;
  localparam int PAYLOAD_LEN = 4 * NPTS;
  localparam int LONG_HOLD   = 300;
  localparam int ITEMS       = 1400;

  typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  typedef struct {
    logic        kind;
    logic [15:0] distance;
    logic [7:0]  number;
    logic [7:0]  ct;
    logic [15:0] start_angle;
    logic [15:0] end_angle;
    logic        checksum_ok;
    logic        last;
  } scan_report_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic [0:0]         m_tuser;
  logic               m_tlast;

  lidar_packet_deframer_xor_check_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // bench copy of the deframer state
  int           frame_pos;
  logic [15:0]  run_xor;
  logic [7:0]   lo_byte;
  logic [7:0]   pkt_ct;
  logic [15:0]  pkt_a0;
  logic [15:0]  pkt_a1;
  logic [15:0]  pkt_sum;

  scan_report_t pending_reports[$];
  int           accepted_bytes;
  int           fails;

  bit           tx_gaps;
  bit           rx_gaps;
  bit           long_hold_req;
  int           rx_stall;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int tx_gap_len();
    if (!tx_gaps) return 0;
    if ($urandom_range(0, 99) < 65) return 0;
    return gap_len();
  endfunction

  // Advance the bench deframer by one accepted byte and queue its reports.
  task automatic deframe_byte(input logic [7:0] b);
    logic [15:0]  w;
    int           k;
    int           n;
    scan_report_t r[2];
    w = {b, lo_byte};
    n = 0;
    accepted_bytes++;
    case (frame_pos)
      0: if (b == SYNC_A) frame_pos = 1;
      1: begin
        if (b == SYNC_B) begin
          run_xor   = SYNC_WORD;
          frame_pos = 2;
        end else begin
          frame_pos = 0;
        end
      end
      2: begin
        pkt_ct    = b;
        frame_pos = 3;
      end
      3: begin
        if (b == COUNT_BYTE) begin
          run_xor   = run_xor ^ {COUNT_BYTE, pkt_ct};
          frame_pos = 4;
        end else begin
          frame_pos = 0;
        end
      end
      4, 6, 8: begin
        lo_byte   = b;
        frame_pos = frame_pos + 1;
      end
      5: begin
        pkt_a0    = w;
        run_xor   = run_xor ^ w;
        frame_pos = 6;
      end
      7: begin
        pkt_a1    = w;
        run_xor   = run_xor ^ w;
        frame_pos = 8;
      end
      9: begin
        pkt_sum   = w;
        frame_pos = HEADER_LEN;
      end
      default: begin
        k = frame_pos - HEADER_LEN;
        if (k % 2 == 0) begin
          lo_byte = b;
        end else begin
          run_xor = run_xor ^ w;
          if (k % 4 == 3) begin
            r[n] = '{KIND_POINT, w, 8'(k / 4), pkt_ct, pkt_a0, pkt_a1, 1'b0, 1'b0};
            n++;
          end
        end
        if (k == PAYLOAD_LEN - 1) begin
          r[n] = '{KIND_SUMMARY, 16'h0, 8'h0, pkt_ct, pkt_a0, pkt_a1,
                   run_xor == pkt_sum, 1'b0};
          n++;
          frame_pos = 0;
        end else begin
          frame_pos = frame_pos + 1;
        end
      end
    endcase
    if (n > 0) r[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_reports.insert(pending_reports.size(), r[i]);
  endtask

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endfunction

  task automatic check_report();
    scan_report_t want;
    if (pending_reports.size() == 0) begin
      $error("unexpected report: tdata 0x%0h tuser %0b", m_tdata, m_tuser);
      fails++;
      return;
    end
    want = pending_reports.pop_front();
    check_field("result_kind", want.kind, m_tuser[0]);
    check_field("point_distance", want.distance, m_tdata[15:0]);
    check_field("point_number", want.number, m_tdata[23:16]);
    check_field("ct_byte", want.ct, m_tdata[31:24]);
    check_field("start_angle", want.start_angle, m_tdata[47:32]);
    check_field("end_angle", want.end_angle, m_tdata[63:48]);
    check_field("checksum_ok", want.checksum_ok, m_tdata[64]);
    check_field("tdata padding", 16'h0, m_tdata[TDATA_W-1:65]);
    check_field("last_of_run", want.last, m_tlast);
  endtask

  // Sample both streams on the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) deframe_byte(s_tdata);
      if (m_tvalid && m_tready) check_report();
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        rx_stall      = LONG_HOLD;
      end
      if (rx_stall > 0) begin
        m_tready <= 1'b0;
        rx_stall = rx_stall - 1;
      end else if (rx_gaps && $urandom_range(0, 99) < 20) begin
        m_tready <= 1'b0;
        rx_stall = gap_len() - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Offer one byte and hold it until accepted; called and left at a falling edge.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    gap = tx_gap_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
  endtask

  task automatic send_packet(input logic [7:0] ct, input logic [15:0] a0, a1,
                             input fill_t fill, input bit bad_sum);
    logic [7:0]  pay[PAYLOAD_LEN];
    logic [7:0]  v;
    logic [15:0] sum;
    sum = SYNC_WORD ^ {COUNT_BYTE, ct} ^ a0 ^ a1;
    for (int i = 0; i < PAYLOAD_LEN; i++) begin
      case (fill)
        FILL_ZERO: v = 8'h00;
        FILL_ONES: v = 8'hFF;
        default:   v = 8'($urandom_range(0, 255));
      endcase
      pay[i] = v;
      if (i % 2 == 1) sum = sum ^ {v, pay[i-1]};
    end
    if (bad_sum) sum = sum ^ (16'h1 << $urandom_range(0, 15));
    send_byte(SYNC_A);
    send_byte(SYNC_B);
    send_byte(ct);
    send_byte(COUNT_BYTE);
    send_byte(a0[7:0]);
    send_byte(a0[15:8]);
    send_byte(a1[7:0]);
    send_byte(a1[15:8]);
    send_byte(sum[7:0]);
    send_byte(sum[15:8]);
    foreach (pay[i]) send_byte(pay[i]);
  endtask

  task automatic send_noise();
    int len;
    len = $urandom_range(1, 12);
    repeat (len) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_broken_header();
    logic [7:0] v;
    send_byte(SYNC_A);
    if ($urandom_range(0, 1) == 0) begin
      do v = 8'($urandom_range(0, 255)); while (v == SYNC_B);
      send_byte(v);
    end else begin
      send_byte(SYNC_B);
      send_byte(8'($urandom_range(0, 255)));
      do v = 8'($urandom_range(0, 255)); while (v == COUNT_BYTE);
      send_byte(v);
    end
  endtask

  // Junk while hunting, a repeated first sync byte, bad second sync and bad count.
  task automatic test_hunting_and_bad_headers();
    logic [7:0] seq[$];
    seq = '{8'h00, 8'hFF, SYNC_B, COUNT_BYTE,
            SYNC_A, SYNC_A, SYNC_B,
            SYNC_A, 8'h00,
            SYNC_A, SYNC_B, 8'h00, 8'h27,
            SYNC_A, SYNC_B, 8'hFF, 8'h29,
            SYNC_A, SYNC_B, SYNC_A, SYNC_B};
    foreach (seq[i]) send_byte(seq[i]);
    wait_for_drain();
  endtask

  // Field extremes with a matching checksum, then a mismatching one.
  task automatic test_packet_extremes();
    send_packet(8'hFF, 16'hFFFF, 16'hFFFF, FILL_ONES, 1'b0);
    send_packet(8'h00, 16'h0000, 16'h0000, FILL_ZERO, 1'b1);
    wait_for_drain();
  endtask

  // Hold the receiver off while a full packet is offered back to back.
  task automatic test_output_backpressure();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    @(posedge clk);
    long_hold_req = 1'b1;
    @(negedge clk);
    send_packet(8'($urandom_range(0, 255)), 16'($urandom), 16'($urandom),
                FILL_RANDOM, 1'b0);
    wait_for_drain();
  endtask

  // Pause the sender until every report is out, then go on with the next packet.
  task automatic test_sender_pause();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    send_packet(8'($urandom_range(0, 255)), 16'($urandom), 16'($urandom),
                FILL_RANDOM, 1'b1);
    wait_for_drain();
    send_packet(8'($urandom_range(0, 255)), 16'($urandom), 16'($urandom),
                FILL_RANDOM, 1'b0);
    wait_for_drain();
  endtask

  // Stop early enough that a final packet lands the total near the item count.
  task automatic test_random_stream();
    int r;
    while (accepted_bytes < ITEMS - int'(HEADER_LEN) - PAYLOAD_LEN / 2) begin
      tx_gaps = $urandom_range(0, 3) != 0;
      rx_gaps = $urandom_range(0, 3) != 0;
      r = $urandom_range(0, 99);
      if (r < 70)
        send_packet(8'($urandom_range(0, 255)), 16'($urandom), 16'($urandom),
                    FILL_RANDOM, $urandom_range(0, 3) == 0);
      else if (r < 85)
        send_noise();
      else
        send_broken_header();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    test_hunting_and_bad_headers();
    test_packet_extremes();
    test_output_backpressure();
    test_sender_pause();
    test_random_stream();
    s_tvalid <= 1'b0;
    for (int i = 0; i < 20000 && pending_reports.size() != 0; i++) @(negedge clk);
    repeat (10) @(posedge clk);
    if (pending_reports.size() != 0) begin
      $error("%0d reports never arrived", pending_reports.size());
      fails++;
    end
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- lidar_packet_deframer_xor_check_top.f -----
rtl/lpdx_pkg.sv
rtl/lidar_packet_deframer_xor_check_top.sv
dv/tb.sv
